// ===== src/spq_pkg.sv =====
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int TAG_BITS  = 8;
  localparam int PRIO_BITS = 16;
  localparam int POS_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REPRIO = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_DUP       = 2'd3;

  typedef struct packed {
    logic [1:0]           op;
    logic [TAG_BITS-1:0]  item_tag;
    logic [PRIO_BITS-1:0] priority_req;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                moved;
    logic [POS_BITS-1:0] position;
    logic [CNT_BITS-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

endpackage

// ===== src/sorted_priority_queue.sv =====
// Sorted priority queue: holds up to DEPTH tags in one slot memory, ordered by
// descending priority (slot 0 is the head; equal priorities keep arrival
// order). A command word is taken when start is high and busy is low; the
// block then stays busy until its result word appears on result for exactly
// one cycle with done high. The receiver cannot stall: capture result on
// every done. Each command makes one pass over the slot memory (one read per
// cycle, read data registered) to look for the tag, collect its neighbors'
// order and count the entries that sort ahead; then, when entries have to
// slide, a prime step and a step for each slid entry, and, except for a
// remove, a write of the new entry. The longest command is a reprioritize
// that carries the tail of a full queue to the head; errors finish right
// after the pass, and in-place updates add only the write. The single read
// and single write port of the slot memory make entries slide one at a time.
// After reset the queue is empty; a slot that holds no entry may be read, but
// that data is never used.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic done,
  output rsp_t result
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_PRIME  = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_FINAL  = 3'd5;

  // Slot memory: one write port, one registered read port.
  entry_t mem [DEPTH];
  entry_t rdata;
  logic   we;
  logic [POS_BITS-1:0] waddr;
  entry_t wdata;
  logic [POS_BITS-1:0] rd_addr;

  logic [2:0]           st;
  cmd_t                 cmd_r;
  logic [CNT_BITS-1:0]  occ;
  logic [CNT_BITS-1:0]  cnt;
  logic [CNT_BITS-1:0]  ge_cnt;
  logic                 found;
  logic [POS_BITS-1:0]  idx;
  logic                 just_found;
  logic                 up_cond;
  logic                 down_cond;
  logic [PRIO_BITS-1:0] last_prio;
  logic [POS_BITS-1:0]  dst;
  logic [POS_BITS-1:0]  last;
  logic                 dir_up;
  logic                 do_final;
  logic [POS_BITS-1:0]  final_pos;

  // Scan helpers: rdata holds entry cnt-1 while cnt is nonzero.
  logic                hit;
  logic [POS_BITS-1:0] scan_j;
  logic [POS_BITS-1:0] dst_next;
  logic [POS_BITS-1:0] ins_pos;

  assign hit      = (rdata.tag == cmd_r.item_tag);
  assign scan_j   = POS_BITS'(cnt - CNT_BITS'(1));
  assign dst_next = dir_up ? (dst - POS_BITS'(1)) : (dst + POS_BITS'(1));
  assign ins_pos  = ge_cnt[POS_BITS-1:0];
  assign busy     = (st != S_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  // Memory port steering.
  always_comb begin
    rd_addr = cnt[POS_BITS-1:0];
    we      = 1'b0;
    waddr   = dst;
    wdata   = rdata;
    unique case (st)
      S_PRIME: begin
        rd_addr = dir_up ? (dst - POS_BITS'(1)) : (dst + POS_BITS'(1));
      end
      S_SHIFT: begin
        we      = 1'b1;
        rd_addr = dir_up ? (dst_next - POS_BITS'(1)) : (dst_next + POS_BITS'(1));
      end
      S_FINAL: begin
        we    = 1'b1;
        waddr = final_pos;
        wdata = '{tag: cmd_r.item_tag, prio: cmd_r.priority_req};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      occ  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (start) begin
            cmd_r      <= cmd;
            cnt        <= '0;
            ge_cnt     <= '0;
            found      <= 1'b0;
            just_found <= 1'b0;
            up_cond    <= 1'b0;
            down_cond  <= 1'b0;
            st         <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (cnt != '0) begin
            // Evaluate entry cnt-1.
            just_found <= hit;
            last_prio  <= rdata.prio;
            if (hit) begin
              found   <= 1'b1;
              idx     <= scan_j;
              up_cond <= (cnt != CNT_BITS'(1)) && (cmd_r.priority_req > last_prio);
            end else if (rdata.prio >= cmd_r.priority_req) begin
              ge_cnt <= ge_cnt + CNT_BITS'(1);
            end
            if (just_found) begin
              down_cond <= (cmd_r.priority_req < rdata.prio);
            end
          end
          if (cnt == occ) begin
            st <= S_DECIDE;
          end else begin
            cnt <= cnt + CNT_BITS'(1);
          end
        end

        S_DECIDE: begin
          result.status      <= ST_OK;
          result.moved       <= 1'b0;
          result.position    <= '0;
          result.entry_count <= occ;
          do_final           <= 1'b0;
          st                 <= S_IDLE;
          done               <= 1'b1;
          unique case (cmd_r.op)
            OP_INSERT: begin
              if (found) begin
                result.status <= ST_DUP;
              end else if (occ == CNT_BITS'(DEPTH)) begin
                result.status <= ST_FULL;
              end else begin
                // Slide entries ins_pos..occ-1 up one slot, then write.
                result.position    <= ins_pos;
                result.entry_count <= occ + CNT_BITS'(1);
                occ                <= occ + CNT_BITS'(1);
                final_pos          <= ins_pos;
                do_final           <= 1'b1;
                done               <= 1'b0;
                dst                <= occ[POS_BITS-1:0];
                last               <= ins_pos + POS_BITS'(1);
                dir_up             <= 1'b1;
                st                 <= (ge_cnt < occ) ? S_PRIME : S_FINAL;
              end
            end
            OP_REMOVE: begin
              if (!found) begin
                result.status <= ST_NOT_FOUND;
              end else begin
                result.position    <= idx;
                result.entry_count <= occ - CNT_BITS'(1);
                occ                <= occ - CNT_BITS'(1);
                dst                <= idx;
                last               <= POS_BITS'(occ - CNT_BITS'(2));
                dir_up             <= 1'b0;
                if (CNT_BITS'(idx) + CNT_BITS'(1) < occ) begin
                  done <= 1'b0;
                  st   <= S_PRIME;
                end
              end
            end
            OP_REPRIO: begin
              if (!found) begin
                result.status <= ST_NOT_FOUND;
              end else begin
                done      <= 1'b0;
                do_final  <= 1'b1;
                dst       <= idx;
                if (up_cond) begin
                  result.moved    <= 1'b1;
                  result.position <= ins_pos;
                  final_pos       <= ins_pos;
                  last            <= ins_pos + POS_BITS'(1);
                  dir_up          <= 1'b1;
                  st              <= S_PRIME;
                end else if (down_cond) begin
                  result.moved    <= 1'b1;
                  result.position <= ins_pos;
                  final_pos       <= ins_pos;
                  last            <= ins_pos - POS_BITS'(1);
                  dir_up          <= 1'b0;
                  st              <= S_PRIME;
                end else begin
                  // Order holds: rewrite the priority in place.
                  result.position <= idx;
                  final_pos       <= idx;
                  st              <= S_FINAL;
                end
              end
            end
            default: begin
            end
          endcase
        end

        S_PRIME: begin
          st <= S_SHIFT;
        end

        S_SHIFT: begin
          if (dst == last) begin
            if (do_final) begin
              st <= S_FINAL;
            end else begin
              st   <= S_IDLE;
              done <= 1'b1;
            end
          end else begin
            dst <= dst_next;
          end
        end

        S_FINAL: begin
          st   <= S_IDLE;
          done <= 1'b1;
        end

        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  // The result word is delivered as the sequencer returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_BITS'(DEPTH))
    else $error("occupancy beyond depth");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (!result.moved && result.position == '0))
    else $error("error result carries a position or move");

  a_moved_reprio: assert property (@(posedge clk) disable iff (rst)
    (done && result.moved) |-> (cmd_r.op == OP_REPRIO && result.status == ST_OK))
    else $error("moved flag on a command other than reprioritize");

endmodule
